[rtl/swps_pkg.sv]
package swps_pkg;

	localparam int unsigned MIN_W      = 32;
	localparam int unsigned SCALE_W    = 40;
	localparam int unsigned SPEED_W    = 32;
	localparam int unsigned DIR_W      = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = SCALE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_LOW    = 2'd2;

	localparam logic [MIN_W-1:0]   MIN_INTERVAL_RST = 32'd25000;
	localparam logic [SCALE_W-1:0] SCALE_HIGH_RST   = 40'd63727125260;
	localparam logic [SCALE_W-1:0] SCALE_LOW_RST    = 40'd39216692468;

	localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
	localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

	localparam logic [SPEED_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;

	// one quotient bit per cycle
	localparam int unsigned          DIV_CNT_W = $clog2(SCALE_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(SCALE_W - 1);

	// control handed from the divider to the job queue
	typedef struct packed {
		logic valid;
		logic take;
	} swps_qctl_t;

endpackage

[rtl/slotted_wheel_period_speed_unit.sv]
// An accepted event's speed result passes through the job take from the queue,
// 40 restoring divide steps of one quotient bit each, and the result load.
// The bit-serial divider works on one qualifying event at a time; a two-entry job
// queue absorbs bursts, and events are accepted while the queue is not full.
// Reset (arst_n low, asynchronous): registers return to their defaults, the stored
// stamp and level clear, queue and output register empty.
module slotted_wheel_period_speed_unit #(
	parameter int unsigned STAMP_WIDTH = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [swps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [swps_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                push,
	output logic                                full,
	input  logic [STAMP_WIDTH-1:0]              timestamp,
	input  logic                                level,
	input  logic [swps_pkg::DIR_W-1:0]          motor_dir,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [swps_pkg::SPEED_W-1:0] speed
);
	import swps_pkg::*;

	localparam int unsigned JOB_W = STAMP_WIDTH + SCALE_W + DIR_W;

	logic             accept;
	logic             job_push;
	logic [JOB_W-1:0] job_wdata;
	logic             job_valid;
	logic [JOB_W-1:0] job_rdata;
	swps_qctl_t       qctl;

	assign accept = push && !full;

	swps_front #(
		.STAMP_WIDTH(STAMP_WIDTH),
		.JOB_W      (JOB_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.timestamp(timestamp),
		.level    (level),
		.motor_dir(motor_dir),
		.job_push (job_push),
		.job_data (job_wdata)
	);

	swps_queue #(
		.JOB_W(JOB_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_wdata),
		.full    (full),
		.ctl     (qctl),
		.rd_valid(job_valid),
		.rd_data (job_rdata)
	);

	swps_back #(
		.STAMP_WIDTH(STAMP_WIDTH),
		.JOB_W      (JOB_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_data (job_rdata),
		.qctl     (qctl),
		.pop      (pop),
		.empty    (empty),
		.speed    (speed)
	);

endmodule

[rtl/swps_front.sv]
module swps_front #(
	parameter int unsigned STAMP_WIDTH = 48,
	parameter int unsigned JOB_W       = STAMP_WIDTH + 40 + 2
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [swps_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [swps_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   accept,
	input  logic [STAMP_WIDTH-1:0]                 timestamp,
	input  logic                                   level,
	input  logic [swps_pkg::DIR_W-1:0]             motor_dir,
	output logic                                   job_push,
	output logic [JOB_W-1:0]                       job_data
);
	import swps_pkg::*;

	localparam int unsigned CMP_W = (STAMP_WIDTH > MIN_W) ? STAMP_WIDTH : MIN_W;

	logic [MIN_W-1:0]       min_interval_q;
	logic [SCALE_W-1:0]     scale_high_q;
	logic [SCALE_W-1:0]     scale_low_q;
	logic [STAMP_WIDTH-1:0] prev_stamp_q;
	logic                   prev_level_q;

	logic [STAMP_WIDTH-1:0] interval;
	logic                   long_enough;
	logic [SCALE_W-1:0]     scale;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q <= MIN_INTERVAL_RST;
			scale_high_q   <= SCALE_HIGH_RST;
			scale_low_q    <= SCALE_LOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_INTERVAL: min_interval_q <= cfg_data[MIN_W-1:0];
				CFG_SCALE_HIGH:   scale_high_q   <= cfg_data[SCALE_W-1:0];
				CFG_SCALE_LOW:    scale_low_q    <= cfg_data[SCALE_W-1:0];
				default:          ;
			endcase
		end
	end

	// wraps modulo the stamp width
	assign interval    = timestamp - prev_stamp_q;
	assign long_enough = CMP_W'(interval) > CMP_W'(min_interval_q);
	assign scale       = level ? scale_high_q : scale_low_q;

	assign job_push = accept && long_enough && (level != prev_level_q);
	assign job_data = {motor_dir, scale, interval};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_stamp_q <= '0;
			prev_level_q <= 1'b0;
		end else if (accept) begin
			prev_stamp_q <= timestamp;
			prev_level_q <= level;
		end
	end

endmodule

[rtl/swps_queue.sv]
module swps_queue #(
	parameter int unsigned JOB_W = 90
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [JOB_W-1:0]      wr_data,
	output logic                  full,
	input  swps_pkg::swps_qctl_t  ctl,
	output logic                  rd_valid,
	output logic [JOB_W-1:0]      rd_data
);
	import swps_pkg::*;

	// two entries, so one-bit pointers
	logic [JOB_W-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_rd;

	assign full     = count_q == 2'd2;
	assign rd_valid = count_q != 2'd0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_rd    = ctl.take && ctl.valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

endmodule

[rtl/swps_back.sv]
module swps_back #(
	parameter int unsigned STAMP_WIDTH = 48,
	parameter int unsigned JOB_W       = STAMP_WIDTH + 40 + 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                job_valid,
	input  logic [JOB_W-1:0]                    job_data,
	output swps_pkg::swps_qctl_t                qctl,
	input  logic                                pop,
	output logic                                empty,
	output logic signed [swps_pkg::SPEED_W-1:0] speed
);
	import swps_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_HOLD
	} state_t;

	state_t                 state_q;
	logic [STAMP_WIDTH-1:0] divisor_q;
	logic [STAMP_WIDTH-1:0] rem_q;
	logic [SCALE_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [DIR_W-1:0]       dir_q;
	logic                   out_valid_q;
	logic [SPEED_W-1:0]     speed_q;

	logic [STAMP_WIDTH:0]   trial;
	logic                   ge;
	logic [STAMP_WIDTH:0]   diff;
	logic [SPEED_W-1:0]     mag;
	logic [SPEED_W-1:0]     signed_speed;
	logic                   load_out;

	// restoring divide step: shift the next dividend bit into the remainder
	assign trial = {rem_q, quo_q[SCALE_W-1]};
	assign ge    = trial >= {1'b0, divisor_q};
	assign diff  = trial - {1'b0, divisor_q};

	always_comb begin
		mag = (|quo_q[SCALE_W-1:SPEED_W-1]) ? SPEED_MAX : quo_q[SPEED_W-1:0];
		case (dir_q)
			DIR_STOP: signed_speed = '0;
			DIR_REV:  signed_speed = '0 - mag;
			default:  signed_speed = mag;
		endcase
	end

	assign load_out   = (state_q == S_HOLD) && (!out_valid_q || pop);
	assign qctl.valid = job_valid;
	assign qctl.take  = (state_q == S_IDLE) && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			divisor_q   <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			cnt_q       <= '0;
			dir_q       <= DIR_STOP;
			out_valid_q <= 1'b0;
			speed_q     <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						divisor_q <= job_data[STAMP_WIDTH-1:0];
						quo_q     <= job_data[STAMP_WIDTH +: SCALE_W];
						dir_q     <= job_data[STAMP_WIDTH + SCALE_W +: DIR_W];
						rem_q     <= '0;
						cnt_q     <= '0;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= ge ? diff[STAMP_WIDTH-1:0] : trial[STAMP_WIDTH-1:0];
					quo_q <= {quo_q[SCALE_W-2:0], ge};
					if (cnt_q == DIV_LAST) begin
						state_q <= S_HOLD;
					end else begin
						cnt_q <= cnt_q + DIV_CNT_W'(1);
					end
				end
				S_HOLD: begin
					// wait for the output register to free up
					if (load_out) begin
						speed_q <= signed_speed;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign empty = !out_valid_q;
	assign speed = signed'(speed_q);

endmodule

[rtl/swps_checker.sv]
module swps_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                push,
	input logic                                full,
	input logic                                pop,
	input logic                                empty,
	input logic signed [swps_pkg::SPEED_W-1:0] speed
);
	import swps_pkg::*;

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(speed))
		else $error("result changed while waiting");

	// saturation keeps the magnitude at or below the positive limit
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> speed != signed'({1'b1, {(SPEED_W-1){1'b0}}}))
		else $error("speed outside the saturated range");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("queue filled without an input transaction");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result dropped without a pop");

endmodule

bind slotted_wheel_period_speed_unit swps_checker u_swps_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.push  (push),
	.full  (full),
	.pop   (pop),
	.empty (empty),
	.speed (speed)
);

[tb/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import swps_pkg::*;

	localparam int unsigned STAMP_W = 48;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam logic [DIR_W-1:0] DIR_SPARE = 2'd3;
	localparam int unsigned DRAIN_CYCLES = 60;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned PHASES = 6;
	localparam int unsigned EVENTS_PER_PHASE = 270;
	localparam int unsigned MAX_PRINTED = 200;

	typedef logic [STAMP_W-1:0] stamp_t;
	typedef logic [SPEED_W-1:0] speed_t;

	class speed_predictor;
		logic [MIN_W-1:0] min_ticks;
		logic [SCALE_W-1:0] scale_high;
		logic [SCALE_W-1:0] scale_low;
		stamp_t last_stamp;
		logic last_level;
		speed_t pending_speeds[$];
		int unsigned mismatches;

		function new();
			min_ticks = MIN_INTERVAL_RST;
			scale_high = SCALE_HIGH_RST;
			scale_low = SCALE_LOW_RST;
			last_stamp = '0;
			last_level = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_MIN_INTERVAL: min_ticks = data[MIN_W-1:0];
				CFG_SCALE_HIGH: scale_high = data[SCALE_W-1:0];
				CFG_SCALE_LOW: scale_low = data[SCALE_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_event(stamp_t stamp, logic lvl, logic [DIR_W-1:0] dir);
			stamp_t ticks;
			logic [63:0] mag;
			ticks = stamp - last_stamp;
			// a zero interval never clears the strict minimum, so no divide by zero
			if (ticks > {16'd0, min_ticks} && lvl != last_level) begin
				mag = (lvl ? scale_high : scale_low) / ticks;
				if (mag > SPEED_MAX)
					mag = SPEED_MAX;
				case (dir)
					DIR_STOP: pending_speeds.push_back('0);
					DIR_REV: pending_speeds.push_back(-mag[SPEED_W-1:0]);
					default: pending_speeds.push_back(mag[SPEED_W-1:0]);
				endcase
			end
			last_stamp = stamp;
			last_level = lvl;
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= MAX_PRINTED)
				$display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		task check_speed(speed_t got);
			speed_t want;
			if (pending_speeds.size() == 0) begin
				report($sformatf("speed %h with no transaction pending", got));
			end else begin
				want = pending_speeds.pop_front();
				if (got !== want)
					report($sformatf("speed %h, expected %h", got, want));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_INTERVAL;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	stamp_t timestamp = '0;
	logic level = 1'b0;
	logic [DIR_W-1:0] motor_dir = DIR_STOP;
	logic empty;
	logic pop = 1'b0;
	logic signed [SPEED_W-1:0] speed;

	speed_predictor speeds;
	stamp_t cur_stamp = '0;
	logic cur_level = 1'b0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;
	int unsigned cycle_count = 0;

	slotted_wheel_period_speed_unit #(.STAMP_WIDTH(STAMP_W)) DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// calm stretches give back-to-back transactions
	function automatic int unsigned draw_gap(inout bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 9);
	endfunction

	task automatic push_event(stamp_t stamp, logic lvl, logic [DIR_W-1:0] dir);
		int unsigned gap;
		gap = draw_gap(send_calm);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		timestamp <= stamp;
		level <= lvl;
		motor_dir <= dir;
		do @(posedge clk); while (full);
		speeds.note_event(stamp, lvl, dir);
		cur_stamp = stamp;
		cur_level = lvl;
	endtask

	task automatic load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		speeds.set_reg(idx, data);
		@(posedge clk);
	endtask

	// hold until every result is back, then let a dropped event finish
	task automatic settle();
		push <= 1'b0;
		while (speeds.pending_speeds.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [SCALE_W-1:0] rand_scale();
		logic [63:0] wide;
		wide = {$urandom, $urandom};
		return wide[SCALE_W-1:0];
	endfunction

	task automatic configure_phase(int unsigned phase);
		logic [CFG_DATA_W-1:0] junk_min;
		junk_min = {8'h5A, 32'd25000};
		case (phase)
			0: begin
				// upper data bits are dropped for the 32-bit register
				load_reg(CFG_MIN_INTERVAL, junk_min);
				load_reg(CFG_SCALE_HIGH, SCALE_HIGH_RST);
				load_reg(CFG_SCALE_LOW, SCALE_LOW_RST);
			end
			1: begin
				load_reg(CFG_MIN_INTERVAL, '0);
				load_reg(CFG_SCALE_HIGH, '1);
				load_reg(CFG_SCALE_LOW, '1);
			end
			2: begin
				load_reg(CFG_MIN_INTERVAL, 40'hFF_FFFF_FFFF);
				load_reg(CFG_SCALE_HIGH, rand_scale());
				load_reg(CFG_SCALE_LOW, rand_scale());
			end
			3: begin
				load_reg(CFG_MIN_INTERVAL, $urandom_range(0, 2000));
				load_reg(CFG_SCALE_HIGH, '0);
				load_reg(CFG_SCALE_LOW, rand_scale());
			end
			4: begin
				load_reg(CFG_MIN_INTERVAL, $urandom);
				load_reg(CFG_SCALE_HIGH, rand_scale());
				load_reg(CFG_SCALE_LOW, '1);
			end
			default: begin
				load_reg(CFG_MIN_INTERVAL, $urandom_range(100, 100000));
				load_reg(CFG_SCALE_HIGH, rand_scale());
				load_reg(CFG_SCALE_LOW, rand_scale());
			end
		endcase
	endtask

	task automatic random_events(int unsigned count);
		stamp_t step;
		logic lvl;
		logic [DIR_W-1:0] dir;
		logic [63:0] wide;
		logic [MIN_W:0] above_min;
		repeat (count) begin
			wide = {$urandom, $urandom};
			above_min = speeds.min_ticks + 1;
			case ($urandom_range(0, 19))
				0, 1: step = $urandom_range(0, speeds.min_ticks);
				2: step = speeds.min_ticks;
				3: step = above_min;
				4: step = wide[STAMP_W-1:0];
				5, 6: step = above_min + wide[31:0];
				7, 8, 9: step = above_min + wide[19:0];
				default: step = above_min + wide[9:0];
			endcase
			lvl = ($urandom_range(0, 6) == 0) ? cur_level : !cur_level;
			case ($urandom_range(0, 9))
				0: dir = DIR_STOP;
				1: dir = DIR_SPARE;
				2, 3, 4: dir = DIR_REV;
				default: dir = DIR_FWD;
			endcase
			push_event(cur_stamp + step, lvl, dir);
		end
	endtask

	initial begin : result_side
		int unsigned gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap(recv_calm);
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			speeds.check_speed(speed);
		end
	end

	initial begin : stimulus
		speeds = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero interval, interval at the minimum, one above
		push_event(48'd0, 1'b1, DIR_FWD);
		push_event(48'd25000, 1'b0, DIR_FWD);
		push_event(48'd50001, 1'b1, DIR_FWD);
		push_event(48'd100000, 1'b1, DIR_FWD);
		push_event(48'd200000, 1'b0, DIR_REV);
		push_event(48'd300000, 1'b1, DIR_STOP);
		push_event(48'd400000, 1'b0, DIR_SPARE);
		push_event('1, 1'b1, DIR_FWD);
		// stamp wraps through zero
		push_event(48'd39999, 1'b0, DIR_REV);
		push_event(48'd65000, 1'b1, DIR_FWD);
		settle();

		// saturate the quotient with a one-tick interval
		load_reg(CFG_MIN_INTERVAL, '0);
		load_reg(CFG_SCALE_HIGH, '1);
		load_reg(CFG_SCALE_LOW, '1);
		load_reg(CFG_SPARE, '1);
		push_event(48'd65001, 1'b0, DIR_FWD);
		push_event(48'd65002, 1'b1, DIR_REV);
		push_event(48'd65003, 1'b0, DIR_STOP);
		push_event(48'd65003, 1'b1, DIR_FWD);
		settle();

		load_reg(CFG_SCALE_HIGH, '0);
		load_reg(CFG_SCALE_LOW, '0);
		push_event(48'd70000, 1'b0, DIR_REV);
		push_event(48'd80000, 1'b1, DIR_FWD);
		settle();

		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			configure_phase(phase);
			random_events(EVENTS_PER_PHASE);
			settle();
		end

		if (speeds.pending_speeds.size() != 0)
			speeds.report($sformatf("%0d speeds never arrived", speeds.pending_speeds.size()));
		if (speeds.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/swps_pkg.sv
rtl/swps_front.sv
rtl/swps_queue.sv
rtl/swps_back.sv
rtl/slotted_wheel_period_speed_unit.sv
rtl/swps_checker.sv
tb/tb.sv
